>>> rtl/ltw_pkg.sv
// Shared types and constants for the two-wire LED driver writer.
// Holds wire event codes, command bytes and the controller/datapath structs.
// Depends on nothing; ltw_ctrl, ltw_datapath and the top unit refer to it by scoped names.
package ltw_pkg;

    // Digit positions that the input item carries
    localparam int MAX_DIGITS        = 4;
    localparam int DIGIT_COUNT_DEF   = 4;

    // Wire event codes
    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_BIT    = 2'd1;
    localparam logic [1:0] EV_ACK    = 2'd2;
    localparam logic [1:0] EV_STOP   = 2'd3;

    // Opcodes
    localparam logic OP_DIGITS       = 1'b0;
    localparam logic OP_BRIGHT       = 1'b1;

    // Command bytes sent to the driver
    localparam logic [7:0] CMD_DATA   = 8'h40;
    localparam logic [7:0] CMD_ADDR   = 8'hC0;
    localparam logic [7:0] CMD_BRIGHT = 8'h88;

    typedef logic [7:0] t_byte;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;      // capture the incoming transaction
        logic       emit;      // write one event into the output register
        logic [1:0] kind;      // event code to emit
        logic       last;      // final event of the command
        logic       bit_adv;   // step to the next bit of the current byte
        logic       byte_adv;  // step to the next byte
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can take an event this cycle
        logic bit_last;    // current bit is the eighth of its byte
        logic bright;      // held command is a brightness write
        logic first_byte;  // current byte is the first of the command
        logic last_byte;   // current byte is the final one of the command
    } t_stat;

endpackage

>>> rtl/ltw_if.sv
// Valid/ready channel interfaces for command and wire event transactions.
// Depends on nothing beyond the field widths of the block.
interface ltw_cmd_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] digit_zero;
    logic [7:0] digit_one;
    logic [7:0] digit_two;
    logic [7:0] digit_three;
    logic [2:0] brightness_level;

    modport source (
        output valid, opcode, digit_zero, digit_one, digit_two, digit_three,
               brightness_level,
        input  ready
    );
    modport sink (
        input  valid, opcode, digit_zero, digit_one, digit_two, digit_three,
               brightness_level,
        output ready
    );
endinterface

interface ltw_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic       data_bit;
    logic       last_event;

    modport source (
        output valid, event_kind, data_bit, last_event,
        input  ready
    );
    modport sink (
        input  valid, event_kind, data_bit, last_event,
        output ready
    );
endinterface

>>> rtl/ltw_ctrl.sv
// Sequencer for the wire events of one command: start, bits, ack, stop.
// Depends on ltw_pkg for event codes and the command/status structs.
module ltw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ltw_pkg::t_stat i_stat,
    output ltw_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_BIT   = 3'd2;
    localparam logic [2:0] S_ACK   = 3'd3;
    localparam logic [2:0] S_STOP  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_final, n_final;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = ltw_pkg::EV_START;
                    n_state    = S_BIT;
                end
            end
            S_BIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = ltw_pkg::EV_BIT;
                    o_cmd.bit_adv = 1'b1;
                    if (i_stat.bit_last) begin
                        n_state = S_ACK;
                    end
                end
            end
            S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = ltw_pkg::EV_ACK;
                    o_cmd.byte_adv = 1'b1;
                    if (i_stat.last_byte) begin
                        n_state = S_STOP;
                        n_final = 1'b1;
                    end else if (i_stat.first_byte && !i_stat.bright) begin
                        // data command frame closes before the address frame
                        n_state = S_STOP;
                        n_final = 1'b0;
                    end else begin
                        n_state = S_BIT;
                    end
                end
            end
            S_STOP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = ltw_pkg::EV_STOP;
                    o_cmd.last = r_final;
                    n_state    = r_final ? S_IDLE : S_START;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

endmodule

>>> rtl/ltw_datapath.sv
// Datapath: held command, bit and byte counters, byte select, output register.
// Depends on ltw_pkg for codes, command bytes and the command/status structs.
module ltw_datapath #(
    parameter int DIGIT_COUNT = ltw_pkg::DIGIT_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_opcode,
    input  logic [7:0]     i_digit_zero,
    input  logic [7:0]     i_digit_one,
    input  logic [7:0]     i_digit_two,
    input  logic [7:0]     i_digit_three,
    input  logic [2:0]     i_brightness_level,
    input  ltw_pkg::t_cmd  i_cmd,
    output ltw_pkg::t_stat o_stat,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [1:0]     o_event_kind,
    output logic           o_data_bit,
    output logic           o_last_event
);

    localparam int IDX_W = $clog2(DIGIT_COUNT + 2);

    logic                r_opcode;
    ltw_pkg::t_byte      r_digit [ltw_pkg::MAX_DIGITS];
    logic [2:0]          r_level;
    logic [2:0]          r_bit_cnt;
    logic [IDX_W-1:0]    r_byte_idx;
    logic                r_out_valid;
    logic [1:0]          r_kind;
    logic                r_data_bit;
    logic                r_last;

    logic [IDX_W-1:0]    digit_off;
    logic [1:0]          digit_sel;
    ltw_pkg::t_byte      cur_byte;
    logic                out_free;

    // Pick the byte now on the wire
    assign digit_off = r_byte_idx - IDX_W'(2);
    assign digit_sel = digit_off[1:0];

    always_comb begin
        if (r_opcode == ltw_pkg::OP_BRIGHT) begin
            cur_byte = ltw_pkg::CMD_BRIGHT | {5'b0, r_level};
        end else if (r_byte_idx == IDX_W'(0)) begin
            cur_byte = ltw_pkg::CMD_DATA;
        end else if (r_byte_idx == IDX_W'(1)) begin
            cur_byte = ltw_pkg::CMD_ADDR;
        end else begin
            cur_byte = r_digit[digit_sel];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Status back to the controller
    always_comb begin
        o_stat.out_free   = out_free;
        o_stat.bit_last   = (r_bit_cnt == 3'd7);
        o_stat.bright     = (r_opcode == ltw_pkg::OP_BRIGHT);
        o_stat.first_byte = (r_byte_idx == IDX_W'(0));
        o_stat.last_byte  = (r_opcode == ltw_pkg::OP_BRIGHT)
                            ? (r_byte_idx == IDX_W'(0))
                            : (r_byte_idx == IDX_W'(DIGIT_COUNT + 1));
    end

    // Capture the command transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode   <= i_opcode;
            r_digit[0] <= i_digit_zero;
            r_digit[1] <= i_digit_one;
            r_digit[2] <= i_digit_two;
            r_digit[3] <= i_digit_three;
            r_level    <= i_brightness_level;
        end
    end

    // Advance bit and byte counters; the bit counter wraps after eight bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt  <= '0;
            r_byte_idx <= '0;
        end else if (i_cmd.load) begin
            r_bit_cnt  <= '0;
            r_byte_idx <= '0;
        end else begin
            if (i_cmd.bit_adv) begin
                r_bit_cnt <= r_bit_cnt + 3'd1;
            end
            if (i_cmd.byte_adv) begin
                r_byte_idx <= r_byte_idx + IDX_W'(1);
            end
        end
    end

    // Hold the event until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind     <= i_cmd.kind;
            r_data_bit <= (i_cmd.kind == ltw_pkg::EV_BIT) ? cur_byte[r_bit_cnt] : 1'b0;
            r_last     <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_data_bit   = r_data_bit;
    assign o_last_event = r_last;

endmodule

>>> rtl/led_driver_two_wire_writer_unit.sv
// Two-wire LED driver writer: turns a command transaction into wire events.
// The first event reaches the output register after the sequencer enters its start state.
// Throughput: one event per cycle while the sink is ready, set by the event
// sequencer stepping one event at a time; a new command is taken only after
// the stop event of the current one is emitted. Synchronous reset
// returns the sequencer to idle and empties the output register.
// Depends on ltw_pkg, ltw_if, ltw_ctrl and ltw_datapath.
module led_driver_two_wire_writer_unit #(
    parameter int DIGIT_COUNT = ltw_pkg::DIGIT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ltw_cmd_if.sink    i_cmd,
    ltw_evt_if.source  o_evt
);

    ltw_pkg::t_cmd  cmd;
    ltw_pkg::t_stat stat;
    logic           in_ready;

    assign i_cmd.ready = in_ready;

    ltw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ltw_datapath #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_opcode           (i_cmd.opcode),
        .i_digit_zero       (i_cmd.digit_zero),
        .i_digit_one        (i_cmd.digit_one),
        .i_digit_two        (i_cmd.digit_two),
        .i_digit_three      (i_cmd.digit_three),
        .i_brightness_level (i_cmd.brightness_level),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_out_ready        (o_evt.ready),
        .o_out_valid        (o_evt.valid),
        .o_event_kind       (o_evt.event_kind),
        .o_data_bit         (o_evt.data_bit),
        .o_last_event       (o_evt.last_event)
    );

    // The final event of a command is always a stop condition
    a_last_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid && o_evt.last_event |-> o_evt.event_kind == ltw_pkg::EV_STOP)
        else $error("last event is not a stop condition");

    // The data line is low on every event other than a data bit clock
    a_bit_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid && o_evt.event_kind != ltw_pkg::EV_BIT |-> !o_evt.data_bit)
        else $error("data bit set on a non-bit event");

    // A new command is not taken in the cycle after one was accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("command accepted while another is in flight");

    // Hold a stalled event and its fields until the sink takes it
    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid && !o_evt.ready |=> o_evt.valid && $stable(o_evt.event_kind)
            && $stable(o_evt.data_bit) && $stable(o_evt.last_event))
        else $error("stalled event changed before it was taken");

endmodule
